FILE: hdl/pole_pkg.sv
// pole_pkg: shared types and constants for the positional ordered list engine
// no dependencies; used by pole_cell and positional_ordered_list_engine

package pole_pkg;

    // fixed field widths of the request and result words
    localparam int REQ_W     = 2;
    localparam int POS_W     = 5;
    localparam int VAL_W     = 32;
    localparam int IDX_OUT_W = 4;
    localparam int CNT_OUT_W = 5;

    // request codes
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FIND   = 2'd2;

    // control states of the engine
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FIND,
        ST_DONE
    } t_state;

    // source selection for one storage cell
    typedef enum logic [2:0] {
        SEL_HOLD,
        SEL_NEW,
        SEL_LEFT,
        SEL_RIGHT,
        SEL_WRAP
    } t_sel;

endpackage

FILE: hdl/pole_cell.sv
// pole_cell: one storage cell of the list, holds a single 32-bit entry
// depends on pole_pkg for t_sel and the value width

module pole_cell (
    input  logic                      i_clk,
    input  pole_pkg::t_sel            i_sel,
    input  logic [pole_pkg::VAL_W-1:0] i_new,
    input  logic [pole_pkg::VAL_W-1:0] i_left,
    input  logic [pole_pkg::VAL_W-1:0] i_right,
    input  logic [pole_pkg::VAL_W-1:0] i_wrap,
    output logic [pole_pkg::VAL_W-1:0] o_entry
);

    logic [pole_pkg::VAL_W-1:0] r_entry;
    logic [pole_pkg::VAL_W-1:0] n_entry;

    // pick the next entry from the neighbors, the new value or the ring wrap
    always_comb begin
        unique case (i_sel)
            pole_pkg::SEL_HOLD:  n_entry = r_entry;
            pole_pkg::SEL_NEW:   n_entry = i_new;
            pole_pkg::SEL_LEFT:  n_entry = i_left;
            pole_pkg::SEL_RIGHT: n_entry = i_right;
            pole_pkg::SEL_WRAP:  n_entry = i_wrap;
            default:             n_entry = r_entry;
        endcase
    end

    // payload register, no reset
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

FILE: hdl/positional_ordered_list_engine.sv
// positional_ordered_list_engine: bounded ordered list with insert, delete and find
// depends on pole_pkg and pole_cell
//
// Usage
//   Input channel: i_in_valid / o_in_stall carry one request word
//   (i_req_type, i_position, i_value). Output channel: o_out_valid / i_out_stall
//   carry one result word (o_ok, o_found_index, o_entry_count) per request.
//   The list lives in a row of CAPACITY cells. Insert and delete shift the cells
//   toward or away from the given position when the request is taken, and their
//   result word is registered with that shift. Find rotates the occupied cells
//   through cell 0, which compares against the key; a full turn restores the
//   order. A find rotates once per occupied entry in ST_FIND, then posts its
//   result word from ST_DONE; on an empty list the result word (o_ok low) is
//   registered as the request is taken.
//   One request is worked on at a time; o_in_stall is high during a find and
//   while a posted result word is held by i_out_stall.
//   Reset (i_rst_n low, synchronous) empties the list and drops any pending
//   result; cell contents are not cleared and are never read before written.
//   A stalled result word is held unchanged until taken.

module positional_ordered_list_engine #(
    parameter int CAPACITY = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [pole_pkg::REQ_W-1:0]          i_req_type,
    input  logic [pole_pkg::POS_W-1:0]          i_position,
    input  logic signed [pole_pkg::VAL_W-1:0]   i_value,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_ok,
    output logic [pole_pkg::IDX_OUT_W-1:0]      o_found_index,
    output logic [pole_pkg::CNT_OUT_W-1:0]      o_entry_count
);

    localparam int IW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > pole_pkg::POS_W) ? CW : pole_pkg::POS_W;

    pole_pkg::t_state r_state, n_state;
    logic [CW-1:0]                    r_count, n_count;
    logic [CW-1:0]                    r_step, n_step;
    logic                             r_hit, n_hit;
    logic [IW-1:0]                    r_fidx, n_fidx;
    logic [pole_pkg::VAL_W-1:0]       r_key, n_key;
    logic                             r_out_valid, n_out_valid;
    logic                             r_ok, n_ok;
    logic [pole_pkg::IDX_OUT_W-1:0]   r_idx, n_idx;
    logic [pole_pkg::CNT_OUT_W-1:0]   r_cnt, n_cnt;

    logic                             w_accept;
    logic                             w_out_free;
    logic                             w_ins_ok;
    logic                             w_del_ok;
    logic                             w_find_go;
    logic                             w_match;
    logic [CMPW-1:0]                  w_pos_x;
    logic [CMPW-1:0]                  w_cnt_x;
    logic [IW-1:0]                    w_last;
    logic [pole_pkg::VAL_W-1:0]       w_entry [CAPACITY];

    // handshake and request decode
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != pole_pkg::ST_IDLE) || !w_out_free;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_pos_x    = CMPW'(i_position);
    assign w_cnt_x    = CMPW'(r_count);
    assign w_ins_ok   = (i_req_type == pole_pkg::REQ_INSERT) && (w_pos_x <= w_cnt_x)
                        && (r_count < CW'(CAPACITY));
    assign w_del_ok   = (i_req_type == pole_pkg::REQ_DELETE) && (w_pos_x < w_cnt_x);
    assign w_find_go  = (i_req_type == pole_pkg::REQ_FIND) && (r_count != '0);
    assign w_last     = IW'(r_count - CW'(1));
    assign w_match    = (w_entry[0] == r_key);

    // row of cells with per-cell source selection
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        localparam logic [CMPW-1:0] CI  = CMPW'(g);
        localparam logic [IW-1:0]   CIX = IW'(g);

        pole_pkg::t_sel            w_sel;
        logic [pole_pkg::VAL_W-1:0] w_left;
        logic [pole_pkg::VAL_W-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = w_entry[0];
        end else begin : g_mid_l
            assign w_left = w_entry[g-1];
        end

        if (g == CAPACITY - 1) begin : g_end
            assign w_right = w_entry[g];
        end else begin : g_mid_r
            assign w_right = w_entry[g+1];
        end

        // insert opens a gap at the position, delete closes it, find rotates
        always_comb begin
            w_sel = pole_pkg::SEL_HOLD;
            priority if (r_state == pole_pkg::ST_FIND) begin
                if (CIX < w_last) begin
                    w_sel = pole_pkg::SEL_RIGHT;
                end else if (CIX == w_last) begin
                    w_sel = pole_pkg::SEL_WRAP;
                end
            end else if (w_accept && w_ins_ok) begin
                if (CI == w_pos_x) begin
                    w_sel = pole_pkg::SEL_NEW;
                end else if (CI > w_pos_x) begin
                    w_sel = pole_pkg::SEL_LEFT;
                end
            end else if (w_accept && w_del_ok) begin
                if (CI >= w_pos_x) begin
                    w_sel = pole_pkg::SEL_RIGHT;
                end
            end else begin
                w_sel = pole_pkg::SEL_HOLD;
            end
        end

        pole_cell u_cell (
            .i_clk   (i_clk),
            .i_sel   (w_sel),
            .i_new   (i_value),
            .i_left  (w_left),
            .i_right (w_right),
            .i_wrap  (w_entry[0]),
            .o_entry (w_entry[g])
        );
    end

    // next state and result word
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_step      = r_step;
        n_hit       = r_hit;
        n_fidx      = r_fidx;
        n_key       = r_key;
        n_out_valid = r_out_valid;
        n_ok        = r_ok;
        n_idx       = r_idx;
        n_cnt       = r_cnt;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            pole_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (w_find_go) begin
                        n_state = pole_pkg::ST_FIND;
                        n_key   = i_value;
                        n_step  = '0;
                        n_hit   = 1'b0;
                        n_fidx  = '0;
                    end else begin
                        if (w_ins_ok) begin
                            n_count = r_count + CW'(1);
                        end else if (w_del_ok) begin
                            n_count = r_count - CW'(1);
                        end
                        n_out_valid = 1'b1;
                        n_ok        = w_ins_ok || w_del_ok;
                        n_idx       = '0;
                        n_cnt       = pole_pkg::CNT_OUT_W'(n_count);
                    end
                end
            end
            pole_pkg::ST_FIND: begin
                // cell 0 sees entry r_step of the list on this cycle
                if (w_match && !r_hit) begin
                    n_hit  = 1'b1;
                    n_fidx = IW'(r_step);
                end
                n_step = r_step + CW'(1);
                if (r_step == r_count - CW'(1)) begin
                    n_state = pole_pkg::ST_DONE;
                end
            end
            pole_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_ok        = r_hit;
                    n_idx       = pole_pkg::IDX_OUT_W'(r_fidx);
                    n_cnt       = pole_pkg::CNT_OUT_W'(r_count);
                    n_state     = pole_pkg::ST_IDLE;
                end
            end
            default: n_state = pole_pkg::ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pole_pkg::ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_step      <= '0;
            r_hit       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_step      <= n_step;
            r_hit       <= n_hit;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_fidx <= n_fidx;
        r_key  <= n_key;
        r_ok   <= n_ok;
        r_idx  <= n_idx;
        r_cnt  <= n_cnt;
    end

    assign o_out_valid   = r_out_valid;
    assign o_ok          = r_ok;
    assign o_found_index = r_idx;
    assign o_entry_count = r_cnt;

    // list length stays within the cell row
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("list length beyond capacity");

    // a successful insert grows the list by exactly one
    a_insert_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_ins_ok) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow the list");

    // the rotation step never runs past the occupied cells
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pole_pkg::ST_FIND) |-> (r_step < r_count))
        else $error("find rotation past list end");

    // no request is taken while a find is rotating
    a_find_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pole_pkg::ST_FIND) |=> !$past(w_accept))
        else $error("request taken during find");

endmodule
